FILE: hw/rtl/life_generation_row_stream_macros.svh
// ----------------------------------------------------------------------------
// life_generation_row_stream_macros.svh
// Assertion macros for the Life row stream block. Define NO_ASSERTIONS to
// compile them away.
// ----------------------------------------------------------------------------
`ifndef LIFE_GENERATION_ROW_STREAM_MACROS_SVH
`define LIFE_GENERATION_ROW_STREAM_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while in reset
`define LGRS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while in reset
`define LGRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LGRS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define LGRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/lgrs_pkg.sv
// ----------------------------------------------------------------------------
// lgrs_pkg
// Shared constants, types and helpers of the Life row stream block.
// ----------------------------------------------------------------------------
`default_nettype none

package lgrs_pkg;

    localparam int ROW_CELLS = 64;
    localparam int WIDTH_W   = 7;
    localparam int NBR_CNT_W = 4;

    localparam logic [WIDTH_W-1:0]   ROW_WIDTH_RESET = 7'd64;
    localparam logic [WIDTH_W-1:0]   ROW_WIDTH_MAX   = 7'(ROW_CELLS);
    localparam logic [NBR_CNT_W-1:0] BIRTH_COUNT     = 4'd3;
    localparam logic [NBR_CNT_W-1:0] SURVIVE_COUNT   = 4'd2;

    // Result queue geometry
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;
    localparam logic [QCNT_W-1:0] QDEPTH_CNT = 3'(QDEPTH);
    localparam logic [QCNT_W-1:0] QACCEPT_MAX = 3'(QDEPTH - 2);

    typedef logic [ROW_CELLS-1:0] row_t;

    typedef struct packed {
        row_t cells;
        logic run_last;
        logic frame_end;
    } lgrs_result_t;

    typedef struct packed {
        logic first_vld;
        logic second_vld;
    } lgrs_push_t;

    // Mask of the columns in use; zero acts as one, over-range as full row
    function automatic row_t width_mask(input logic [WIDTH_W-1:0] w);
        logic [WIDTH_W-1:0] eff;
        row_t               m;
        eff = w;
        if (eff == '0) eff = 7'd1;
        if (eff > ROW_WIDTH_MAX) eff = ROW_WIDTH_MAX;
        for (int k = 0; k < ROW_CELLS; k++) begin
            m[k] = (7'(k) < eff);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/lgrs_cell.sv
// ----------------------------------------------------------------------------
// lgrs_cell
// One column lane: counts eight neighbours and applies the B3/S23 rule.
// ----------------------------------------------------------------------------
`default_nettype none

module lgrs_cell
    import lgrs_pkg::*;
(
    input  wire logic [7:0] nbr,
    input  wire logic       alive,
    output logic            next_state
);

    logic [NBR_CNT_W-1:0] sum;

    // Count live neighbours
    always_comb begin
        sum = '0;
        for (int i = 0; i < 8; i++) begin
            sum = sum + NBR_CNT_W'(nbr[i]);
        end
    end

    // Born on three, survive on two or three
    assign next_state = (sum == BIRTH_COUNT) || (alive && (sum == SURVIVE_COUNT));

endmodule

`default_nettype wire

FILE: hw/rtl/lgrs_row.sv
// ----------------------------------------------------------------------------
// lgrs_row
// One row generation: a lane per column over a dead-bordered 3-row window,
// merged into one masked row word.
// ----------------------------------------------------------------------------
`default_nettype none

module lgrs_row
    import lgrs_pkg::*;
(
    input  wire row_t upper,
    input  wire row_t middle,
    input  wire row_t lower,
    input  wire row_t mask,
    output row_t      next_cells
);

    logic [ROW_CELLS+1:0] up_ext;
    logic [ROW_CELLS+1:0] mid_ext;
    logic [ROW_CELLS+1:0] low_ext;
    row_t                 lane_out;

    // Drop unused columns and add a dead border on both sides
    assign up_ext  = {1'b0, upper  & mask, 1'b0};
    assign mid_ext = {1'b0, middle & mask, 1'b0};
    assign low_ext = {1'b0, lower  & mask, 1'b0};

    for (genvar c = 0; c < ROW_CELLS; c++) begin : g_lane
        lgrs_cell u_cell (
            .nbr        ({up_ext[c], up_ext[c+1], up_ext[c+2],
                          mid_ext[c], mid_ext[c+2],
                          low_ext[c], low_ext[c+1], low_ext[c+2]}),
            .alive      (mid_ext[c+1]),
            .next_state (lane_out[c])
        );
    end

    // Merge lanes, clear columns past the width
    assign next_cells = lane_out & mask;

endmodule

`default_nettype wire

FILE: hw/rtl/lgrs_out_queue.sv
// ----------------------------------------------------------------------------
// lgrs_out_queue
// Four-entry result queue: takes up to two results a cycle, hands out one while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module lgrs_out_queue
    import lgrs_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire lgrs_push_t   push,
    input  wire lgrs_result_t first_res,
    input  wire lgrs_result_t second_res,
    output logic              room_for_two,
    output logic              out_valid,
    input  wire logic         out_ready,
    output lgrs_result_t      out_res,
    output logic [QCNT_W-1:0] fill
);

    lgrs_result_t        entries_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic [QPTR_W-1:0]   wr_ptr_plus1;
    logic [QCNT_W-1:0]   n_push;
    logic                pop;

    assign pop          = out_valid && out_ready;
    assign n_push       = QCNT_W'(push.first_vld) + QCNT_W'(push.second_vld);
    assign wr_ptr_plus1 = wr_ptr_reg + 2'd1;

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg + n_push[QPTR_W-1:0];
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + n_push - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the results of this transaction
    always_ff @(posedge aclk) begin
        if (push.first_vld) begin
            entries_reg[wr_ptr_reg] <= first_res;
        end
        if (push.second_vld) begin
            entries_reg[wr_ptr_plus1] <= second_res;
        end
    end

    assign out_valid    = (count_reg != '0);
    assign out_res      = entries_reg[rd_ptr_reg];
    assign room_for_two = (count_reg <= QACCEPT_MAX);
    assign fill         = count_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/life_generation_row_stream.sv
// ----------------------------------------------------------------------------
// life_generation_row_stream
// One Game of Life generation (B3/S23) over a grid streamed row by row.
// ----------------------------------------------------------------------------
// Usage: send the grid top to bottom on the s_ channel, one row of up to 64
// cells per transaction, s_tlast high on the bottom row. Each row after the
// first returns the next state of the row above it on the m_ channel; the
// bottom row returns that row and then its own next state (m_tuser high),
// after which the row buffers clear for the next frame. m_tlast marks the
// last result caused by one input transaction. cfg_wr_en/cfg_wr_data set
// the row width; write it only between frames with no results pending.
// Each result is written into the result queue and shown on m_ from there.
// Throughput: one row per cycle while s_tready is high; a bottom row after
// other rows yields two results, handed out in turn. Both results of a
// transaction come from two 64-lane row units in the same cycle and enter a
// four-entry result queue; s_tready is high while two entries are free.
// Reset empties the queue and clears the stored rows; the width returns
// to 64. When the receiver stalls the queue fills and s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

`include "life_generation_row_stream_macros.svh"

module life_generation_row_stream
    import lgrs_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Configuration
    input  wire logic                 cfg_wr_en,
    input  wire logic [WIDTH_W-1:0]   cfg_wr_data,   // row_width
    // Row input
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [ROW_CELLS-1:0] s_tdata,       // [63:0] row_cells
    input  wire logic                 s_tlast,       // last_row
    // Result output
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [ROW_CELLS-1:0]      m_tdata,       // [63:0] next_row_cells
    output logic                      m_tlast,       // run_last
    output logic                      m_tuser        // [0] frame_end
);

    logic [WIDTH_W-1:0] row_width_reg;
    row_t               upper_reg, upper_next;
    row_t               middle_reg, middle_next;
    logic               have_middle_reg, have_middle_next;

    row_t               mask;
    row_t               gen_above;
    row_t               gen_own;
    logic               in_acc;
    lgrs_push_t         push;
    lgrs_result_t       first_res;
    lgrs_result_t       second_res;
    lgrs_result_t       out_res;
    logic               room_for_two;
    logic [QCNT_W-1:0]  fill;

    // Hold the row width
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg <= ROW_WIDTH_RESET;
        end else if (cfg_wr_en) begin
            row_width_reg <= cfg_wr_data;
        end
    end

    assign mask     = width_mask(row_width_reg);
    assign s_tready = room_for_two;
    assign in_acc   = s_tvalid && s_tready;

    // Next state of the row above the incoming one
    lgrs_row u_row_above (
        .upper      (upper_reg),
        .middle     (middle_reg),
        .lower      (s_tdata),
        .mask       (mask),
        .next_cells (gen_above)
    );

    // Next state of the incoming row with a dead row below
    lgrs_row u_row_own (
        .upper      (middle_reg),
        .middle     (s_tdata),
        .lower      ('0),
        .mask       (mask),
        .next_cells (gen_own)
    );

    // Pick the results of this transaction
    always_comb begin
        push       = '0;
        first_res  = '{cells: gen_above, run_last: !s_tlast, frame_end: 1'b0};
        second_res = '{cells: gen_own, run_last: 1'b1, frame_end: 1'b1};
        if (in_acc) begin
            if (have_middle_reg) begin
                push.first_vld  = 1'b1;
                push.second_vld = s_tlast;
            end else if (s_tlast) begin
                push.first_vld = 1'b1;
                first_res      = second_res;
            end
        end
    end

    // Shift the row window, clear it after the bottom row
    always_comb begin
        upper_next       = upper_reg;
        middle_next      = middle_reg;
        have_middle_next = have_middle_reg;
        if (in_acc) begin
            if (s_tlast) begin
                upper_next       = '0;
                middle_next      = '0;
                have_middle_next = 1'b0;
            end else begin
                upper_next       = have_middle_reg ? middle_reg : '0;
                middle_next      = s_tdata;
                have_middle_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_reg       <= '0;
            middle_reg      <= '0;
            have_middle_reg <= 1'b0;
        end else begin
            upper_reg       <= upper_next;
            middle_reg      <= middle_next;
            have_middle_reg <= have_middle_next;
        end
    end

    lgrs_out_queue u_queue (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (push),
        .first_res    (first_res),
        .second_res   (second_res),
        .room_for_two (room_for_two),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_res      (out_res),
        .fill         (fill)
    );

    assign m_tdata = out_res.cells;
    assign m_tlast = out_res.run_last;
    assign m_tuser = out_res.frame_end;

    // Checks
    `LGRS_ASSERT_IMPLY(a_fill_bound, aclk, aresetn, 1'b1, fill <= QDEPTH_CNT,
        "result queue overfilled")
    `LGRS_ASSERT_IMPLY(a_width_clear, aclk, aresetn, m_tvalid, (m_tdata & ~mask) == '0,
        "live cell past the row width")
    `LGRS_ASSERT_IMPLY(a_frame_end_last, aclk, aresetn, m_tvalid && m_tuser, m_tlast,
        "frame end without run end")
    `LGRS_ASSERT_NEXT(a_bottom_clears, aclk, aresetn, in_acc && s_tlast,
        !have_middle_reg && (middle_reg == '0) && (upper_reg == '0),
        "row window not cleared after bottom row")

endmodule

`default_nettype wire
